@@ hdl/sha256_pkg.sv @@
// Shared types, constants and round functions of the byte-stream SHA-256 hasher.
// No dependencies.
`default_nettype none
package sha256_pkg;
	localparam int unsigned BLOCK_BYTES = 64;
	localparam int unsigned LEN_POS = 56;
	localparam logic [7:0] PAD_BYTE = 8'h80;

	localparam logic [0:0] ACT_ABSORB = 1'b0;
	localparam logic [0:0] ACT_FINISH = 1'b1;

	typedef logic [31:0] word_t;

	typedef enum logic [2:0] {
		BSEL_DATA,
		BSEL_PAD,
		BSEL_ZERO,
		BSEL_LEN
	} bsel_t;

	typedef struct packed {
		logic  wr_byte;
		bsel_t bsel;
		logic  cnt_clear;
		logic  start;
		logic  emit;
		logic  reinit;
	} cmd_t;

	typedef struct packed {
		logic [5:0] fill;
		logic       busy;
		logic       done;
		logic       out_busy;
	} sts_t;

	localparam word_t ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam word_t INIT_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	function automatic word_t rotr(input word_t x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic word_t bsig0(input word_t x);
		bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic word_t bsig1(input word_t x);
		bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic word_t ssig0(input word_t x);
		ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t ssig1(input word_t x);
		ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction
endpackage
`default_nettype wire

@@ hdl/sha256_if.sv @@
// Valid/ready channel interfaces for input beats and digest beats.
// Depends on nothing.
`default_nettype none
interface sha256_in_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] data_byte;
	modport source (output valid, output action, output data_byte, input ready);
	modport sink (input valid, input action, input data_byte, output ready);
endinterface

interface sha256_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last;
	modport source (output valid, output digest_word, output word_index, output last,
		input ready);
	modport sink (input valid, input digest_word, input word_index, input last,
		output ready);
endinterface
`default_nettype wire

@@ hdl/sha256_byte_stream_hasher_unit.sv @@
// Top level of the byte-stream SHA-256 hasher: controller plus datapath.
// Depends on sha256_pkg, sha256_if, sha256_ctrl and sha256_datapath.
// The 64th byte of a block starts a 64-round compression (one round a cycle),
// during which no beat is taken. A finish beat pads one byte a cycle up to the
// end of the block, compresses once or twice, then offers the eight digest words
// one per cycle while ready is high; the chaining state reloads after the last
// word. Throughput is bounded by the single round unit and the single block
// buffer.
`default_nettype none
module sha256_byte_stream_hasher_unit
	import sha256_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	sha256_in_if.sink    din,
	sha256_out_if.source dout
);
	cmd_t cmd;
	sts_t sts;

	sha256_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (din.valid),
		.in_action (din.action),
		.in_ready  (din.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	sha256_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.data_byte (din.data_byte),
		.sts       (sts),
		.dout      (dout)
	);
endmodule
`default_nettype wire

@@ hdl/sha256_datapath.sv @@
// Datapath: block buffer, schedule window, round unit, chaining words, length and output.
// Depends on sha256_pkg.
`default_nettype none
module sha256_datapath
	import sha256_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cmd_t        cmd,
	input  wire logic [7:0]  data_byte,
	output      sts_t        sts,
	sha256_out_if.source     dout
);
	logic [5:0]  fill_q;
	logic [54:0] blocks_q;
	logic [63:0] len_q;
	word_t       h_q [8];
	word_t       w_q [16];
	word_t       a_q, b_q, c_q, d_q, e_q, f_q, g_q, hh_q;
	logic [5:0]  rnd_q;
	logic        busy_q;
	logic        done_q;
	logic        ov_q;
	logic [2:0]  oi_q;
	logic [7:0]  wbyte;
	word_t       t1, t2, wnew, wcur;
	logic [2:0]  li;

	always_comb begin
		li = fill_q[2:0];
		unique case (cmd.bsel)
			BSEL_DATA: wbyte = data_byte;
			BSEL_PAD:  wbyte = PAD_BYTE;
			BSEL_LEN:  wbyte = len_q[6'd63 - {li, 3'd0} -: 8];
			default:   wbyte = 8'h00;
		endcase
		wcur = w_q[0];
		wnew = ssig1(w_q[14]) + w_q[9] + ssig0(w_q[1]) + w_q[0];
		t1 = hh_q + bsig1(e_q) + ((e_q & f_q) ^ (~e_q & g_q)) + ROUND_K[rnd_q] + wcur;
		t2 = bsig0(a_q) + ((a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q));
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_byte) begin
			for (int i = 0; i < 15; i++)
				w_q[i] <= {w_q[i][23:0], w_q[i+1][31:24]};
			w_q[15] <= {w_q[15][23:0], wbyte};
		end else if (busy_q) begin
			for (int i = 0; i < 15; i++)
				w_q[i] <= w_q[i+1];
			w_q[15] <= wnew;
		end
		if (cmd.start) begin
			a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3];
			e_q <= h_q[4]; f_q <= h_q[5]; g_q <= h_q[6]; hh_q <= h_q[7];
		end else if (busy_q) begin
			hh_q <= g_q; g_q <= f_q; f_q <= e_q; e_q <= d_q + t1;
			d_q <= c_q; c_q <= b_q; b_q <= a_q; a_q <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			blocks_q <= '0;
			len_q    <= '0;
			busy_q   <= 1'b0;
			done_q   <= 1'b0;
			rnd_q    <= '0;
			ov_q     <= 1'b0;
			oi_q     <= '0;
			for (int i = 0; i < 8; i++)
				h_q[i] <= INIT_HASH[i];
		end else begin
			done_q <= 1'b0;
			if (cmd.cnt_clear)
				fill_q <= '0;
			else if (cmd.wr_byte)
				fill_q <= fill_q + 6'd1;
			if (cmd.wr_byte && cmd.bsel == BSEL_PAD)
				len_q <= {blocks_q, fill_q, 3'd0};
			if (cmd.start) begin
				busy_q <= 1'b1;
				rnd_q  <= '0;
			end else if (busy_q) begin
				rnd_q <= rnd_q + 6'd1;
				if (rnd_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					h_q[0] <= h_q[0] + t1 + t2; h_q[1] <= h_q[1] + a_q;
					h_q[2] <= h_q[2] + b_q;     h_q[3] <= h_q[3] + c_q;
					h_q[4] <= h_q[4] + d_q + t1; h_q[5] <= h_q[5] + e_q;
					h_q[6] <= h_q[6] + f_q;     h_q[7] <= h_q[7] + g_q;
					blocks_q <= blocks_q + 55'd1;
				end
			end
			if (cmd.emit) begin
				ov_q <= 1'b1;
				oi_q <= '0;
			end else if (ov_q && dout.ready) begin
				oi_q <= oi_q + 3'd1;
				if (oi_q == 3'd7)
					ov_q <= 1'b0;
			end
			if (cmd.reinit) begin
				blocks_q <= '0;
				for (int i = 0; i < 8; i++)
					h_q[i] <= INIT_HASH[i];
			end
		end
	end

	assign dout.valid       = ov_q;
	assign dout.digest_word = h_q[oi_q];
	assign dout.word_index  = oi_q;
	assign dout.last        = (oi_q == 3'd7);

	assign sts.fill     = fill_q;
	assign sts.busy     = busy_q;
	assign sts.done     = done_q;
	assign sts.out_busy = ov_q;
endmodule
`default_nettype wire

@@ hdl/sha256_ctrl.sv @@
// Controller: sequences absorb, padding, compression and digest output.
// Depends on sha256_pkg.
`default_nettype none
module sha256_ctrl
	import sha256_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire logic in_action,
	output      logic in_ready,
	input  wire sts_t sts,
	output      cmd_t cmd
);
	typedef enum logic [2:0] {
		S_IDLE,
		S_COMP,
		S_PADZ,
		S_LEN,
		S_FCOMP,
		S_DRAIN
	} state_t;

	state_t state_q;
	logic   final_q;
	logic   acc;

	assign in_ready = (state_q == S_IDLE);
	assign acc = in_valid && in_ready;

	always_comb begin
		cmd = '0;
		cmd.bsel = BSEL_DATA;
		unique case (state_q)
			S_IDLE: if (acc) begin
				cmd.wr_byte = 1'b1;
				cmd.bsel = (in_action == ACT_FINISH) ? BSEL_PAD : BSEL_DATA;
				cmd.start = (sts.fill == 6'd63);
			end
			S_PADZ: begin
				cmd.wr_byte = 1'b1;
				cmd.bsel = BSEL_ZERO;
				cmd.start = (sts.fill == 6'd63);
			end
			S_LEN: begin
				cmd.wr_byte = 1'b1;
				cmd.bsel = BSEL_LEN;
				cmd.start = (sts.fill == 6'd63);
			end
			S_COMP, S_FCOMP: ;
			S_DRAIN: ;
			default: ;
		endcase
		cmd.emit = (state_q == S_FCOMP) && sts.done;
		cmd.reinit = (state_q == S_DRAIN) && !sts.out_busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			final_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (acc) begin
					if (in_action == ACT_FINISH)
						state_q <= (sts.fill == 6'd63) ? S_COMP
							: (sts.fill == 6'd55) ? S_LEN : S_PADZ;
					else if (sts.fill == 6'd63)
						state_q <= S_COMP;
					final_q <= (in_action == ACT_FINISH);
				end
				S_PADZ: if (sts.fill == 6'd63)
						state_q <= S_COMP;
					else if (sts.fill == 6'd55 && !sts.busy)
						state_q <= S_LEN;
				S_COMP: if (sts.done)
						state_q <= final_q ? S_PADZ : S_IDLE;
				S_LEN: if (sts.fill == 6'd63)
						state_q <= S_FCOMP;
				S_FCOMP: if (sts.done)
						state_q <= S_DRAIN;
				S_DRAIN: if (!sts.out_busy)
						state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
